@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must hold whenever the qualifier is high.
`define ASSERT_WHEN(label, qual, cond, msg) \
	`ASSERT_CLK(label, (qual) |-> (cond), msg)

`endif

@@ rtl/pwfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pwfe_pkg
// Types and constants of the pulse-width frame encoder.
// ----------------------------------------------------------------------------
package pwfe_pkg;

	localparam int ByteW   = 8;
	localparam int TimeW   = 11;
	localparam int PulseW  = 13;
	localparam int SyncW   = 5;
	localparam int BitCntW = 3;
	localparam int CfgIdxW = 2;

	localparam logic [SyncW-1:0] SyncMax   = 5'd16;
	localparam logic [ByteW-1:0] CheckAdd  = 8'd5;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SYNC_ZERO  = 2'd0,
		REG_SHORT_HIGH = 2'd1,
		REG_LONG_HIGH  = 2'd2,
		REG_BIT_PERIOD = 2'd3
	} reg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;   // capture byte, flag; load sync count, clear bit count
		logic clear_sum;   // first byte of a frame
		logic load_check;  // load checksum byte into shifter
		logic sync_dec;
		logic shift;
		logic emit;
		logic level;
		logic end_mark;
		logic last_pulse;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cur_bit;
		logic sync_zero;
		logic sync_one;
		logic bit_last;
		logic last_q;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/pwfe_if.sv @@
// ----------------------------------------------------------------------------
// pwfe channel interfaces
// Valid/ready channels for bytes in, pulse words out and register writes.
// ----------------------------------------------------------------------------
interface pwfe_in_if;
	logic                          valid;
	logic                          ready;
	logic [pwfe_pkg::ByteW-1:0]    frame_byte;
	logic                          last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface pwfe_out_if;
	logic                          valid;
	logic                          ready;
	logic [pwfe_pkg::PulseW-1:0]   pulse_high_us;
	logic [pwfe_pkg::PulseW-1:0]   pulse_period_us;
	logic                          bit_level;
	logic                          is_end_marker;
	logic                          last_of_run;

	modport source (output valid, pulse_high_us, pulse_period_us, bit_level,
		is_end_marker, last_of_run, input ready);
	modport sink   (input valid, pulse_high_us, pulse_period_us, bit_level,
		is_end_marker, last_of_run, output ready);
endinterface

interface pwfe_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pwfe_pkg::CfgIdxW-1:0]  index;
	logic [pwfe_pkg::TimeW-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/pwfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// pwfe_ctrl
// Sequencer: preamble, sync zeros, start bit, data bits, stop bit, checksum and end marker.
// ----------------------------------------------------------------------------
module pwfe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pwfe_pkg::stat_t  stat,
	output pwfe_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PRE, ST_SYNC, ST_START, ST_DATA, ST_STOP,
		ST_CK_DATA, ST_CK_STOP, ST_END
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   frame_open_q;
	logic   frame_open_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		frame_open_d = frame_open_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_item = 1'b1;
					cmd.clear_sum = !frame_open_q;
					state_d       = frame_open_q ? ST_DATA : ST_PRE;
				end
			end
			ST_PRE: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.level = 1'b1;
					state_d   = stat.sync_zero ? ST_START : ST_SYNC;
				end
			end
			ST_SYNC: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sync_dec = 1'b1;
					if (stat.sync_one) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.level    = 1'b1;
					state_d      = ST_DATA;
					frame_open_d = 1'b1;
				end
			end
			ST_DATA, ST_CK_DATA: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.shift = 1'b1;
					cmd.level = stat.cur_bit;
					if (stat.bit_last) begin
						state_d = (state_q == ST_DATA) ? ST_STOP : ST_CK_STOP;
					end
				end
			end
			ST_STOP: begin
				if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.level      = 1'b1;
					cmd.last_pulse = !stat.last_q;
					cmd.load_check = stat.last_q;
					state_d        = stat.last_q ? ST_CK_DATA : ST_IDLE;
				end
			end
			ST_CK_STOP: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.level = 1'b1;
					state_d   = ST_END;
				end
			end
			ST_END: begin
				if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.level      = 1'b1;
					cmd.end_mark   = 1'b1;
					cmd.last_pulse = 1'b1;
					state_d        = ST_IDLE;
					frame_open_d   = 1'b0;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frame_open_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			frame_open_q <= frame_open_d;
		end
	end

endmodule

@@ rtl/pwfe_dp.sv @@
// ----------------------------------------------------------------------------
// pwfe_dp
// Registers, byte shifter, running sum, counters and the output word register.
// ----------------------------------------------------------------------------
module pwfe_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pwfe_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pwfe_pkg::TimeW-1:0]     cfg_data,
	input  logic [pwfe_pkg::ByteW-1:0]     frame_byte,
	input  logic                           last_byte,
	input  pwfe_pkg::cmd_t                 cmd,
	output pwfe_pkg::stat_t                stat,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [pwfe_pkg::PulseW-1:0]    pulse_high_us,
	output logic [pwfe_pkg::PulseW-1:0]    pulse_period_us,
	output logic                           bit_level,
	output logic                           is_end_marker,
	output logic                           last_of_run
);

	logic [pwfe_pkg::SyncW-1:0]   sync_cfg_q;
	logic [pwfe_pkg::TimeW-1:0]   short_q;
	logic [pwfe_pkg::TimeW-1:0]   long_q;
	logic [pwfe_pkg::TimeW-1:0]   period_q;
	logic [pwfe_pkg::ByteW-1:0]   sum_q;
	logic [pwfe_pkg::ByteW-1:0]   shift_q;
	logic [pwfe_pkg::SyncW-1:0]   sync_cnt_q;
	logic [pwfe_pkg::BitCntW-1:0] bit_cnt_q;
	logic                         last_q;
	logic                         out_valid_q;
	logic [pwfe_pkg::SyncW-1:0]   sync_sat;
	logic [pwfe_pkg::PulseW-1:0]  bit_high;
	logic [pwfe_pkg::PulseW-1:0]  period_ext;
	logic [pwfe_pkg::PulseW-1:0]  mark_high;
	logic [pwfe_pkg::PulseW-1:0]  mark_period;
	logic [pwfe_pkg::PulseW-1:0]  nom_high;
	logic [pwfe_pkg::PulseW-1:0]  nom_period;

	assign sync_sat = (sync_cfg_q > pwfe_pkg::SyncMax) ? pwfe_pkg::SyncMax : sync_cfg_q;

	assign bit_high    = pwfe_pkg::PulseW'(cmd.level ? short_q : long_q);
	assign period_ext  = pwfe_pkg::PulseW'(period_q);
	assign mark_high   = {period_ext[pwfe_pkg::PulseW-2:0], 1'b0}
		+ pwfe_pkg::PulseW'(short_q);
	assign mark_period = {period_ext[pwfe_pkg::PulseW-2:0], 1'b0} + period_ext;
	assign nom_high    = cmd.end_mark ? mark_high : bit_high;
	assign nom_period  = cmd.end_mark ? mark_period : period_ext;

	assign stat.cur_bit   = shift_q[0];
	assign stat.sync_zero = (sync_cnt_q == '0);
	assign stat.sync_one  = (sync_cnt_q == pwfe_pkg::SyncW'(1));
	assign stat.bit_last  = (bit_cnt_q == '1);
	assign stat.last_q    = last_q;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_cfg_q  <= pwfe_pkg::SyncW'(10);
			short_q     <= pwfe_pkg::TimeW'(366);
			long_q      <= pwfe_pkg::TimeW'(854);
			period_q    <= pwfe_pkg::TimeW'(1220);
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (pwfe_pkg::reg_idx_t'(cfg_index))
					pwfe_pkg::REG_SYNC_ZERO:  sync_cfg_q <= cfg_data[pwfe_pkg::SyncW-1:0];
					pwfe_pkg::REG_SHORT_HIGH: short_q    <= cfg_data;
					pwfe_pkg::REG_LONG_HIGH:  long_q     <= cfg_data;
					pwfe_pkg::REG_BIT_PERIOD: period_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_item) begin
				sum_q <= (cmd.clear_sum ? '0 : sum_q) + frame_byte;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			shift_q    <= frame_byte;
			last_q     <= last_byte;
			sync_cnt_q <= sync_sat;
			bit_cnt_q  <= '0;
		end else if (cmd.load_check) begin
			shift_q   <= sum_q + pwfe_pkg::CheckAdd;
			bit_cnt_q <= '0;
		end else begin
			if (cmd.shift) begin
				shift_q   <= {1'b0, shift_q[pwfe_pkg::ByteW-1:1]};
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (cmd.sync_dec) begin
				sync_cnt_q <= sync_cnt_q - 1'b1;
			end
		end
		if (cmd.emit) begin
			pulse_high_us   <= nom_high;
			pulse_period_us <= (nom_period < nom_high) ? nom_high : nom_period;
			bit_level       <= cmd.level;
			is_end_marker   <= cmd.end_mark;
			last_of_run     <= cmd.last_pulse;
		end
	end

endmodule

@@ rtl/pulse_width_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// pulse_width_frame_encoder
// Expands frame bytes into pulse-width symbol words with preamble and checksum.
// ----------------------------------------------------------------------------
// Usage:
//   din  : one frame byte per word, last_byte set on the final byte.
//   dout : one pulse word per symbol; last_of_run marks the final word of a byte.
//   cfg  : register writes (sync zeros, short/long high time, bit period),
//          always ready; write only while the block is idle.
// A byte is taken only while the sequencer is idle. The first word is
// registered by the state after the accept, then one word per cycle while
// dout is ready. Each byte gives its data bits and a stop bit; a frame's
// first byte adds preamble, sync zeros and start bit, the last byte adds the
// checksum byte, its stop bit and the end marker. The sequencer emitting into
// the output register sets the pace; a stalled dout holds the word and the
// sequence. The next byte may be accepted while the final word still waits
// on dout. Reset restores the register defaults and closes any open frame.
// ----------------------------------------------------------------------------
module pulse_width_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	pwfe_in_if.sink     din,
	pwfe_out_if.source  dout,
	pwfe_cfg_if.sink    cfg
);

	pwfe_pkg::cmd_t  cmd;
	pwfe_pkg::stat_t stat;

	assign cfg.ready = 1'b1;

	pwfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pwfe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg.valid && cfg.ready),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.frame_byte      (din.frame_byte),
		.last_byte       (din.last_byte),
		.cmd             (cmd),
		.stat            (stat),
		.out_ready       (dout.ready),
		.out_valid       (dout.valid),
		.pulse_high_us   (dout.pulse_high_us),
		.pulse_period_us (dout.pulse_period_us),
		.bit_level       (dout.bit_level),
		.is_end_marker   (dout.is_end_marker),
		.last_of_run     (dout.last_of_run)
	);

endmodule

@@ rtl/pwfe_checker.sv @@
// ----------------------------------------------------------------------------
// pwfe_checker
// Port-level checks of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwfe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pwfe_pkg::PulseW-1:0]   pulse_high_us,
	input logic [pwfe_pkg::PulseW-1:0]   pulse_period_us,
	input logic                          bit_level,
	input logic                          is_end_marker,
	input logic                          last_of_run
);

	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "word dropped under stall")
	`ASSERT_CLK(a_busy_after_take, in_valid && in_ready |=> !in_ready, "byte taken while busy")
	`ASSERT_WHEN(a_period_ge_high, out_valid, pulse_period_us >= pulse_high_us, "period below high")
	`ASSERT_WHEN(a_marker_fields, out_valid && is_end_marker, bit_level && last_of_run, "bad marker")

endmodule

bind pulse_width_frame_encoder pwfe_checker u_pwfe_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (din.valid),
	.in_ready        (din.ready),
	.out_valid       (dout.valid),
	.out_ready       (dout.ready),
	.pulse_high_us   (dout.pulse_high_us),
	.pulse_period_us (dout.pulse_period_us),
	.bit_level       (dout.bit_level),
	.is_end_marker   (dout.is_end_marker),
	.last_of_run     (dout.last_of_run)
);
